// ----- hw/rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 8-bit palettized bitmap stream parser.
package bsp_pkg;

	localparam int unsigned DEF_MAX_DIM       = 4096;
	localparam int unsigned DEF_PALETTE_BYTES = 1024;
	localparam int unsigned DEF_INFO_USED     = 40;

	// Position counters are 13 bits wide and wrap there.
	localparam int unsigned CNT_W = 13;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;
	localparam logic [7:0] PLANES_ONE = 8'd1;
	localparam logic [7:0] DEPTH_8 = 8'd8;

	// Byte offsets of the header fields.
	localparam int unsigned FSIZE_LO   = 2;
	localparam int unsigned DOFF_LO    = 10;
	localparam int unsigned INFO_LO    = 14;
	localparam int unsigned WIDTH_LO   = 18;
	localparam int unsigned HEIGHT_LO  = 22;
	localparam int unsigned PLANES_OFF = 26;
	localparam int unsigned DEPTH_OFF  = 28;
	localparam int unsigned COMPR_OFF  = 30;

	localparam int unsigned FILE_HDR_BYTES = 14;
	localparam int unsigned MIN_HDR_END    = 18;

	// Format flags: planes ok, depth ok, compressed.
	localparam logic [2:0] FLAGS_OK = 3'b011;

	typedef enum logic [2:0] {
		KIND_HDR    = 3'd0,
		KIND_PAL    = 3'd1,
		KIND_PIX    = 3'd2,
		KIND_NOTBMP = 3'd3,
		KIND_UNSUP  = 3'd4,
		KIND_IGN    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_HDR  = 3'b001,
		ST_BODY = 3'b010,
		ST_REJ  = 3'b100
	} status_t;

	typedef struct packed {
		logic not_bmp;
		logic unsup;
		logic finish;
	} hdr_res_t;

endpackage

// ----- hw/rtl/bsp_hdr.sv -----
`timescale 1ns / 1ps
// Header byte decode: field capture, magic, size and format checks, header end.
module bsp_hdr #(
	parameter int unsigned MAX_DIM       = bsp_pkg::DEF_MAX_DIM,
	parameter int unsigned PALETTE_BYTES = bsp_pkg::DEF_PALETTE_BYTES,
	parameter int unsigned INFO_USED     = bsp_pkg::DEF_INFO_USED,
	localparam int unsigned DIM_W        = $clog2(MAX_DIM + 4)
) (
	input  logic [31:0]      off,
	input  logic [7:0]       b,
	input  logic [31:0]      file_cur,
	input  logic [31:0]      data_cur,
	input  logic [31:0]      info_cur,
	input  logic [DIM_W-1:0] width_cur,
	input  logic [DIM_W-1:0] height_cur,
	input  logic [2:0]       flags_cur,
	output logic [31:0]      file_nxt,
	output logic [31:0]      data_nxt,
	output logic [31:0]      info_nxt,
	output logic [DIM_W-1:0] width_nxt,
	output logic [DIM_W-1:0] height_nxt,
	output logic [2:0]       flags_nxt,
	output logic [DIM_W-1:0] stride_nxt,
	output logic [32:0]      pal_begin,
	output logic [32:0]      pal_lim,
	output bsp_pkg::hdr_res_t res
);
	import bsp_pkg::*;

	logic [31:0] width_w;
	logic [31:0] height_w;
	logic [31:0] used;
	logic [31:0] end_v;
	logic        magic_bad;
	logic        over;
	logic        at_end;
	logic        fmt_ok;

	always_comb begin
		file_nxt  = file_cur;
		data_nxt  = data_cur;
		info_nxt  = info_cur;
		width_w   = 32'(width_cur);
		height_w  = 32'(height_cur);
		flags_nxt = flags_cur;
		for (int k = 0; k < 4; k++) begin
			if (off == 32'(FSIZE_LO + k)) file_nxt[8*k +: 8] = b;
			if (off == 32'(DOFF_LO + k)) data_nxt[8*k +: 8] = b;
			if (off == 32'(INFO_LO + k)) info_nxt[8*k +: 8] = b;
			if (off == 32'(WIDTH_LO + k)) width_w = width_w + (32'(b) << (8 * k));
			if (off == 32'(HEIGHT_LO + k)) height_w = height_w + (32'(b) << (8 * k));
		end
		if (off == 32'(PLANES_OFF) && b == PLANES_ONE) flags_nxt[0] = 1'b1;
		if (off == 32'(DEPTH_OFF) && b == DEPTH_8) flags_nxt[1] = 1'b1;
		if (off == 32'(COMPR_OFF) && b != 8'd0) flags_nxt[2] = 1'b1;
	end

	assign width_nxt  = width_w[DIM_W-1:0];
	assign height_nxt = height_w[DIM_W-1:0];
	assign over       = (width_w > 32'(MAX_DIM)) || (height_w > 32'(MAX_DIM));
	assign magic_bad  = (off == 32'd0 && b != MAGIC_B) || (off == 32'd1 && b != MAGIC_M);

	// Header ends at 14 + min(info length, used part), never before byte 18.
	always_comb begin
		used = (info_nxt < 32'(INFO_USED)) ? info_nxt : 32'(INFO_USED);
		end_v = used + 32'(FILE_HDR_BYTES);
		if (end_v < 32'(MIN_HDR_END)) end_v = 32'(MIN_HDR_END);
	end

	assign at_end = (off >= 32'(MIN_HDR_END - 1)) && (off >= end_v - 32'd1);
	assign fmt_ok = (flags_nxt == FLAGS_OK);

	assign res.not_bmp = magic_bad;
	assign res.unsup   = !magic_bad && (over || (at_end && !fmt_ok));
	assign res.finish  = !magic_bad && !over && at_end && fmt_ok;

	// Round the width up to a multiple of four for the row stride.
	always_comb begin
		stride_nxt = width_nxt + DIM_W'(3);
		stride_nxt[1:0] = 2'b00;
	end

	assign pal_begin = {1'b0, info_nxt} + 33'(FILE_HDR_BYTES);
	assign pal_lim   = {1'b0, info_nxt} + 33'(FILE_HDR_BYTES + PALETTE_BYTES);

endmodule

// ----- hw/rtl/bsp_body.sv -----
`timescale 1ns / 1ps
// Body byte classification: skip, palette or pixel, with pixel position counters.
module bsp_body #(
	parameter int unsigned MAX_DIM = bsp_pkg::DEF_MAX_DIM,
	localparam int unsigned DIM_W  = $clog2(MAX_DIM + 4)
) (
	input  logic [31:0]               off,
	input  logic [32:0]               pal_begin,
	input  logic [32:0]               pal_lim,
	input  logic [31:0]               data_off,
	input  logic [DIM_W-1:0]          stride,
	input  logic [DIM_W-1:0]          height,
	input  logic [bsp_pkg::CNT_W-1:0] col,
	input  logic [bsp_pkg::CNT_W-1:0] row,
	output bsp_pkg::kind_t            kind,
	output logic [9:0]                pal_off,
	output logic [11:0]               px,
	output logic [11:0]               py,
	output logic [bsp_pkg::CNT_W-1:0] col_nxt,
	output logic [bsp_pkg::CNT_W-1:0] row_nxt
);
	import bsp_pkg::*;

	logic [CNT_W:0] col_inc;
	logic [31:0]    stride_w;
	logic [31:0]    height_w;
	logic           row_wrap;

	assign col_inc  = {1'b0, col} + (CNT_W + 1)'(1);
	assign stride_w = 32'(stride);
	assign height_w = 32'(height);
	assign row_wrap = 32'(col_inc) >= stride_w;

	always_comb begin
		kind    = KIND_HDR;
		pal_off = '0;
		px      = '0;
		py      = '0;
		col_nxt = col;
		row_nxt = row;
		if ({1'b0, off} < pal_begin) begin
			kind = KIND_HDR;
		end else if (off < data_off) begin
			if ({1'b0, off} < pal_lim) begin
				kind    = KIND_PAL;
				pal_off = off[9:0] - pal_begin[9:0];
			end
		end else begin
			kind = KIND_PIX;
			px   = col[11:0];
			py   = height_w[11:0] - row[11:0] - 12'd1;
			if (row_wrap) begin
				col_nxt = '0;
				row_nxt = row + CNT_W'(1);
			end else begin
				col_nxt = col_inc[CNT_W-1:0];
			end
		end
	end

endmodule

// ----- hw/rtl/bmp_8bit_stream_parser.sv -----
`timescale 1ns / 1ps
// Bitmap stream parser: one file byte in, one classified result out per transaction.
// Latency: the result is valid in the cycle after the byte's transaction.
// Throughput: one byte per cycle while results are taken; the result register frees as it is taken.
// Reset: all parse state clears as at the start of a file; no result pending.
// The header decode and body classification sit between the state and result registers.
module bmp_8bit_stream_parser #(
	parameter int unsigned MAX_DIM       = bsp_pkg::DEF_MAX_DIM,
	parameter int unsigned PALETTE_BYTES = bsp_pkg::DEF_PALETTE_BYTES,
	parameter int unsigned INFO_USED     = bsp_pkg::DEF_INFO_USED
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        first_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [9:0]  palette_offset,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [7:0]  value,
	output logic        file_done
);
	import bsp_pkg::*;

	localparam int unsigned DIM_W = $clog2(MAX_DIM + 4);

	// Parse state
	logic [31:0]      off_q;
	logic [31:0]      file_q;
	logic [31:0]      data_q;
	logic [31:0]      info_q;
	logic [DIM_W-1:0] stride_q;
	logic [DIM_W-1:0] height_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [2:0]       flags_q;
	status_t          status_q;
	logic [32:0]      pal_begin_q;
	logic [32:0]      pal_lim_q;

	// Result register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [9:0]  pal_off_q;
	logic [11:0] px_q;
	logic [11:0] py_q;
	logic [7:0]  value_q;
	logic        done_q;

	// State as seen by this byte: a new file starts from cleared state.
	logic [31:0]      off_c;
	logic [31:0]      file_c;
	logic [31:0]      data_c;
	logic [31:0]      info_c;
	logic [DIM_W-1:0] stride_c;
	logic [DIM_W-1:0] height_c;
	logic [CNT_W-1:0] col_c;
	logic [CNT_W-1:0] row_c;
	logic [2:0]       flags_c;
	status_t          status_c;

	// Header decode outputs
	logic [31:0]      h_file;
	logic [31:0]      h_data;
	logic [31:0]      h_info;
	logic [DIM_W-1:0] h_width;
	logic [DIM_W-1:0] h_height;
	logic [2:0]       h_flags;
	logic [DIM_W-1:0] h_stride;
	logic [32:0]      h_pal_begin;
	logic [32:0]      h_pal_lim;
	hdr_res_t         h_res;

	// Body classification outputs
	kind_t            b_kind;
	logic [9:0]       b_pal_off;
	logic [11:0]      b_px;
	logic [11:0]      b_py;
	logic [CNT_W-1:0] b_col;
	logic [CNT_W-1:0] b_row;

	// Result of this byte
	kind_t       kind_d;
	logic [9:0]  pal_off_d;
	logic [11:0] px_d;
	logic [11:0] py_d;
	logic [7:0]  value_d;
	logic        done_d;
	logic [31:0] file_sel;

	logic in_fire;

	// Accept whenever the result register is empty or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		if (first_of_file) begin
			off_c    = '0;
			file_c   = '0;
			data_c   = '0;
			info_c   = '0;
			stride_c = '0;
			height_c = '0;
			col_c    = '0;
			row_c    = '0;
			flags_c  = '0;
			status_c = ST_HDR;
		end else begin
			off_c    = off_q;
			file_c   = file_q;
			data_c   = data_q;
			info_c   = info_q;
			stride_c = stride_q;
			height_c = height_q;
			col_c    = col_q;
			row_c    = row_q;
			flags_c  = flags_q;
			status_c = status_q;
		end
	end

	// During the header the stride register still holds the raw width.
	bsp_hdr #(
		.MAX_DIM       (MAX_DIM),
		.PALETTE_BYTES (PALETTE_BYTES),
		.INFO_USED     (INFO_USED)
	) u_hdr (
		.off        (off_c),
		.b          (file_byte),
		.file_cur   (file_c),
		.data_cur   (data_c),
		.info_cur   (info_c),
		.width_cur  (stride_c),
		.height_cur (height_c),
		.flags_cur  (flags_c),
		.file_nxt   (h_file),
		.data_nxt   (h_data),
		.info_nxt   (h_info),
		.width_nxt  (h_width),
		.height_nxt (h_height),
		.flags_nxt  (h_flags),
		.stride_nxt (h_stride),
		.pal_begin  (h_pal_begin),
		.pal_lim    (h_pal_lim),
		.res        (h_res)
	);

	bsp_body #(
		.MAX_DIM (MAX_DIM)
	) u_body (
		.off       (off_c),
		.pal_begin (pal_begin_q),
		.pal_lim   (pal_lim_q),
		.data_off  (data_c),
		.stride    (stride_c),
		.height    (height_c),
		.col       (col_c),
		.row       (row_c),
		.kind      (b_kind),
		.pal_off   (b_pal_off),
		.px        (b_px),
		.py        (b_py),
		.col_nxt   (b_col),
		.row_nxt   (b_row)
	);

	// Pick the result by parse status.
	always_comb begin
		kind_d    = KIND_IGN;
		pal_off_d = '0;
		px_d      = '0;
		py_d      = '0;
		value_d   = '0;
		file_sel  = file_c;
		unique case (status_c)
			ST_HDR: begin
				file_sel = h_file;
				if (h_res.not_bmp) begin
					kind_d = KIND_NOTBMP;
				end else if (h_res.unsup) begin
					kind_d = KIND_UNSUP;
				end else begin
					kind_d = KIND_HDR;
				end
			end
			ST_BODY: begin
				kind_d    = b_kind;
				pal_off_d = b_pal_off;
				px_d      = b_px;
				py_d      = b_py;
				if (b_kind == KIND_PAL || b_kind == KIND_PIX) value_d = file_byte;
			end
			ST_REJ: begin
				kind_d = KIND_IGN;
			end
			default: begin
				kind_d = KIND_IGN;
			end
		endcase
	end

	// Flag the byte that reaches the declared file size.
	assign done_d = (kind_d == KIND_HDR || kind_d == KIND_PAL || kind_d == KIND_PIX)
		&& (off_c >= 32'd5)
		&& (({1'b0, off_c} + 33'd1) == {1'b0, file_sel});

	// Advance the parse state on each transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			file_q      <= '0;
			data_q      <= '0;
			info_q      <= '0;
			stride_q    <= '0;
			height_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			flags_q     <= '0;
			status_q    <= ST_HDR;
			pal_begin_q <= '0;
			pal_lim_q   <= '0;
		end else if (in_fire) begin
			// Saturate the byte offset at all ones.
			off_q <= (off_c == '1) ? off_c : off_c + 32'd1;
			unique case (status_c)
				ST_HDR: begin
					file_q   <= h_file;
					data_q   <= h_data;
					info_q   <= h_info;
					height_q <= h_height;
					flags_q  <= h_flags;
					col_q    <= '0;
					row_q    <= '0;
					if (h_res.not_bmp || h_res.unsup) begin
						stride_q <= h_width;
						status_q <= ST_REJ;
					end else if (h_res.finish) begin
						// Header done: switch to the padded stride and open the body.
						stride_q    <= h_stride;
						pal_begin_q <= h_pal_begin;
						pal_lim_q   <= h_pal_lim;
						status_q    <= ST_BODY;
					end else begin
						stride_q <= h_width;
						status_q <= ST_HDR;
					end
				end
				ST_BODY: begin
					col_q <= b_col;
					row_q <= b_row;
				end
				ST_REJ: begin
					// Hold the parse fields until the next file starts; only the byte offset advances.
					status_q <= ST_REJ;
				end
				default: begin
					status_q <= ST_REJ;
				end
			endcase
		end
	end

	// Result valid: set on a transaction in, drop when taken with nothing new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: load with each accepted byte.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q    <= kind_d;
			pal_off_q <= pal_off_d;
			px_q      <= px_d;
			py_q      <= py_d;
			value_q   <= value_d;
			done_q    <= done_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign palette_offset = pal_off_q;
	assign pixel_x        = px_q;
	assign pixel_y        = py_q;
	assign value          = value_q;
	assign file_done      = done_q;

endmodule
